>>> rtl/core/utps_pkg.sv
package utps_pkg;

  localparam int LA_DEPTH = 8;
  localparam int CNT_W    = $clog2(LA_DEPTH + 1);
  localparam int IDX_W    = $clog2(LA_DEPTH);
  // bytes the decision logic looks at: two code points of up to four bytes
  localparam int WIN      = 8;

  localparam logic [20:0] CP_BAD   = 21'h00FFFD;
  localparam logic [7:0]  CH_APOS  = 8'h27;
  localparam logic [7:0]  CH_SPACE = 8'h20;
  localparam logic [7:0]  CASE_BIT = 8'h20;
  localparam logic [7:0]  CONT_MSK = 8'h3F;

  typedef logic [20:0] cp_t;

  typedef enum logic [2:0] {
    MODE_NONE    = 3'd0,
    MODE_LETTERS = 3'd1,
    MODE_PUNCT   = 3'd2,
    MODE_WS      = 3'd3,
    MODE_NL      = 3'd4
  } mode_t;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_text;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       piece_start;
    logic       last_of_text;
  } out_item_t;

  typedef struct packed {
    logic       go;
    logic       start;
    logic [2:0] take;
    mode_t      mode;
  } dec_t;

  function automatic logic [2:0] seq_len(input logic [7:0] b);
    logic [2:0] l;
    l = 3'd1;
    if (b[7] == 1'b0)            l = 3'd1;
    else if (b[7:5] == 3'b110)   l = 3'd2;
    else if (b[7:4] == 4'b1110)  l = 3'd3;
    else if (b[7:3] == 5'b11110) l = 3'd4;
    return l;
  endfunction

  function automatic cp_t decode(input logic [7:0] b0, input logic [7:0] b1,
                                 input logic [7:0] b2, input logic [7:0] b3);
    cp_t c;
    if (b0[7] == 1'b0)            c = {13'd0, b0};
    else if (b0[7:5] == 3'b110)   c = {10'd0, b0[4:0], b1[5:0]};
    else if (b0[7:4] == 4'b1110)  c = {5'd0, b0[3:0], b1[5:0], b2[5:0]};
    else if (b0[7:3] == 5'b11110) c = {b0[2:0], b1[5:0], b2[5:0], b3[5:0]};
    else                          c = CP_BAD;
    return c;
  endfunction

  function automatic logic in_rng(input cp_t c, input cp_t lo, input cp_t hi);
    return (c >= lo) && (c <= hi);
  endfunction

  function automatic logic is_alpha(input cp_t c);
    return in_rng(c, 21'h41, 21'h5A) || in_rng(c, 21'h61, 21'h7A) ||
           (in_rng(c, 21'hC0, 21'hFF) && c != 21'hD7 && c != 21'hF7) ||
           in_rng(c, 21'h100, 21'h24F) || in_rng(c, 21'h370, 21'h4FF) ||
           in_rng(c, 21'h600, 21'h6FF) || in_rng(c, 21'h900, 21'h97F) ||
           in_rng(c, 21'h4E00, 21'h9FFF) || in_rng(c, 21'h3400, 21'h4DBF) ||
           in_rng(c, 21'hAC00, 21'hD7AF) || in_rng(c, 21'h3040, 21'h30FF) ||
           in_rng(c, 21'hF900, 21'hFAFF) || in_rng(c, 21'hFF21, 21'hFF3A) ||
           in_rng(c, 21'hFF41, 21'hFF5A) || in_rng(c, 21'h0E01, 21'h0E3A) ||
           in_rng(c, 21'h05D0, 21'h05EA) || in_rng(c, 21'h1100, 21'h11FF) ||
           in_rng(c, 21'h2E80, 21'h2EFF) || in_rng(c, 21'h3000, 21'h303F);
  endfunction

  function automatic logic is_mark(input cp_t c);
    return in_rng(c, 21'h0300, 21'h036F) || in_rng(c, 21'h0591, 21'h05BD) ||
           in_rng(c, 21'h0610, 21'h061A) || in_rng(c, 21'h064B, 21'h065F) ||
           in_rng(c, 21'h0900, 21'h0903) || in_rng(c, 21'h093A, 21'h094F) ||
           c == 21'h0E31 || in_rng(c, 21'h0E34, 21'h0E3A) ||
           in_rng(c, 21'hFE20, 21'hFE2F) || in_rng(c, 21'h20D0, 21'h20FF);
  endfunction

  function automatic logic is_numeral(input cp_t c);
    return in_rng(c, 21'h30, 21'h39);
  endfunction

  function automatic logic is_ws(input cp_t c);
    return c == 21'h20 || in_rng(c, 21'h09, 21'h0D) || c == 21'hA0 ||
           c == 21'h1680 || in_rng(c, 21'h2000, 21'h200A) || c == 21'h2028 ||
           c == 21'h2029 || c == 21'h202F || c == 21'h205F || c == 21'h3000;
  endfunction

  function automatic logic is_nl(input cp_t c);
    return c == 21'h0A || c == 21'h0D;
  endfunction

  function automatic logic is_punct(input cp_t c);
    return !is_ws(c) && !is_alpha(c) && !is_mark(c) && !is_numeral(c);
  endfunction

endpackage

>>> rtl/core/utps_lookahead.sv
module utps_lookahead import utps_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     push,
  input  in_item_t                 push_item,
  input  logic                     pop,
  output logic [WIN-1:0][7:0]      win,
  output logic [CNT_W-1:0]         count,
  output logic                     eot_pend
);

  logic [7:0]       la_r   [LA_DEPTH];
  logic [7:0]       la_nxt [LA_DEPTH];
  logic [CNT_W-1:0] cnt_r, cnt_nxt, wpos;
  logic             eot_r, eot_nxt;

  always_comb begin
    for (int i = 0; i < LA_DEPTH; i++) begin
      if (pop && i + 1 < LA_DEPTH) la_nxt[i] = la_r[i + 1];
      else                         la_nxt[i] = la_r[i];
    end
    wpos = cnt_r - CNT_W'(pop);
    if (push) la_nxt[wpos[IDX_W-1:0]] = push_item.text_byte;
    cnt_nxt = cnt_r - CNT_W'(pop) + CNT_W'(push);
    if (push && push_item.end_of_text) eot_nxt = 1'b1;
    else if (pop && cnt_r == CNT_W'(1)) eot_nxt = 1'b0;
    else eot_nxt = eot_r;
  end

  always_ff @(posedge clk) begin
    la_r <= la_nxt;
    if (!rst_n) begin
      cnt_r <= '0;
      eot_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      eot_r <= eot_nxt;
    end
  end

  always_comb begin
    for (int i = 0; i < WIN; i++) win[i] = la_r[i];
  end

  assign count    = cnt_r;
  assign eot_pend = eot_r;

endmodule

>>> rtl/core/utps_decide.sv
module utps_decide import utps_pkg::*; (
  input  logic [WIN-1:0][7:0] win,
  input  logic [CNT_W-1:0]    count,
  input  logic                eot,
  input  mode_t               mode,
  output dec_t                dec
);

  logic [7:0]     bt [WIN];
  logic [7:0]     n0, n1, n2, n3, x, y;
  logic [2:0]     l0, l1, ftake, take;
  logic [CNT_W:0] need1;
  cp_t            c0, c1;
  logic           need0, cont, cont_act, fhold, done, have1;
  mode_t          cmode, fmode;

  always_comb begin
    for (int i = 0; i < WIN; i++) begin
      bt[i] = (CNT_W'(i) < count) ? win[i] : 8'd0;
    end
  end

  always_comb begin
    l0    = seq_len(bt[0]);
    need0 = (CNT_W'(l0) > count) && !eot;
    c0    = decode(bt[0], bt[1], bt[2], bt[3]);

    // continuation of an open piece
    cont  = 1'b0;
    cmode = mode;
    case (mode)
      MODE_LETTERS: cont = is_alpha(c0) || is_mark(c0);
      MODE_PUNCT: begin
        if (is_punct(c0)) cont = 1'b1;
        else if (is_nl(c0)) begin
          cont  = 1'b1;
          cmode = MODE_NL;
        end
      end
      MODE_WS: begin
        if (is_nl(c0)) begin
          cont  = 1'b1;
          cmode = MODE_NL;
        end else if (is_ws(c0)) cont = 1'b1;
      end
      MODE_NL: cont = is_nl(c0);
      default: cont = 1'b0;
    endcase
    cont_act = (mode != MODE_NONE) && cont;

    // second code point, starting right after the first
    case (l0)
      3'd1:    begin n0 = bt[1]; n1 = bt[2]; n2 = bt[3]; n3 = bt[4]; end
      3'd2:    begin n0 = bt[2]; n1 = bt[3]; n2 = bt[4]; n3 = bt[5]; end
      3'd3:    begin n0 = bt[3]; n1 = bt[4]; n2 = bt[5]; n3 = bt[6]; end
      default: begin n0 = bt[4]; n1 = bt[5]; n2 = bt[6]; n3 = bt[7]; end
    endcase
    l1    = seq_len(n0);
    c1    = decode(n0, n1, n2, n3);
    need1 = (CNT_W+1)'(l0) + (CNT_W+1)'(l1);

    // fresh piece
    fhold = 1'b0;
    done  = 1'b0;
    ftake = l0;
    fmode = MODE_NONE;
    have1 = 1'b0;
    x     = bt[1] | CASE_BIT;
    y     = bt[2] | CASE_BIT;
    if (c0 == cp_t'(CH_APOS)) begin
      if (count < CNT_W'(2)) begin
        if (!eot) fhold = 1'b1;
      end else if (x == "s" || x == "t" || x == "m" || x == "d") begin
        ftake = 3'd2;
        done  = 1'b1;
      end else if (x == "r" || x == "v" || x == "l") begin
        if (count < CNT_W'(3)) begin
          if (!eot) fhold = 1'b1;
        end else if (y == ((x == "l") ? 8'h6C : 8'h65)) begin
          ftake = 3'd3;
          done  = 1'b1;
        end
      end
    end
    if (!done && !fhold) begin
      if (is_alpha(c0)) fmode = MODE_LETTERS;
      else if (is_numeral(c0)) fmode = MODE_NONE;
      else if (is_nl(c0)) fmode = MODE_NL;
      else begin
        if (CNT_W'(l0) < count) begin
          if (need1 > (CNT_W+1)'(count) && !eot) fhold = 1'b1;
          have1 = 1'b1;
        end else if (!eot) fhold = 1'b1;
        if (have1 && (is_alpha(c1) || is_mark(c1))) fmode = MODE_LETTERS;
        else if (c0 == cp_t'(CH_SPACE) && have1 && is_punct(c1)) fmode = MODE_PUNCT;
        else if (is_punct(c0)) fmode = MODE_PUNCT;
        else if (is_ws(c0)) fmode = MODE_WS;
        else fmode = MODE_NONE;
      end
    end

    take = cont_act ? l0 : ftake;
    if (CNT_W'(take) > count) take = count[2:0];

    dec.go    = (count != '0) && !need0 && (cont_act || !fhold);
    dec.start = !cont_act;
    dec.take  = take;
    dec.mode  = cont_act ? cmode : fmode;
  end

endmodule

>>> rtl/core/utf8_text_pretoken_splitter_unit.sv
// A taken byte passes the lookahead and then the output register, which loads it once its
//   piece boundary is known (up to the next code point, at most 8 bytes of lookahead).
// Throughput: one byte per cycle in and out, unless a stall or an undecided boundary holds it.
// After an end-of-text byte is taken, in_stall stays high until that text is flushed;
//   it also rises while the lookahead holds 8 bytes.
// Reset (rst_n low, synchronous) empties the lookahead, closes any piece and drops out_valid.
module utf8_text_pretoken_splitter_unit import utps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  logic [WIN-1:0][7:0] win;
  logic [CNT_W-1:0]    count;
  logic                eot_pend, push, fire, can_load, last;
  dec_t                dec;
  mode_t               mode_r, mode_nxt;
  logic [1:0]          rem_r, rem_nxt;
  logic                ov_r, ov_nxt;
  out_item_t           oi_r, oi_nxt;

  assign in_stall = eot_pend || (count == CNT_W'(LA_DEPTH));
  assign push     = in_valid && !in_stall;

  utps_lookahead u_la (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (in_item),
    .pop       (fire),
    .win       (win),
    .count     (count),
    .eot_pend  (eot_pend)
  );

  utps_decide u_dec (
    .win   (win),
    .count (count),
    .eot   (eot_pend),
    .mode  (mode_r),
    .dec   (dec)
  );

  // trailing bytes of a multi-byte take drain without a new decision
  always_comb begin
    can_load = !ov_r || !out_stall;
    fire     = can_load && (((rem_r != 2'd0) && (count != '0)) || dec.go);
    last     = eot_pend && (count == CNT_W'(1));

    oi_nxt.out_byte     = win[0];
    oi_nxt.piece_start  = (rem_r == 2'd0) && dec.start;
    oi_nxt.last_of_text = last;

    rem_nxt  = rem_r;
    mode_nxt = mode_r;
    if (fire) begin
      if (rem_r != 2'd0) rem_nxt = rem_r - 2'd1;
      else begin
        rem_nxt  = 2'(dec.take - 3'd1);
        mode_nxt = dec.mode;
      end
      if (last) begin
        rem_nxt  = 2'd0;
        mode_nxt = MODE_NONE;
      end
    end

    if (fire) ov_nxt = 1'b1;
    else if (out_stall) ov_nxt = ov_r;
    else ov_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (fire) oi_r <= oi_nxt;
    if (!rst_n) begin
      ov_r   <= 1'b0;
      rem_r  <= 2'd0;
      mode_r <= MODE_NONE;
    end else begin
      ov_r   <= ov_nxt;
      rem_r  <= rem_nxt;
      mode_r <= mode_nxt;
    end
  end

  assign out_valid = ov_r;
  assign out_item  = oi_r;

endmodule

>>> rtl/core/utps_checker.sv
module utps_checker import utps_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_item_t  in_item,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_item
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_item))
    else $error("stalled output item changed");

  a_eot_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_item.end_of_text |=> in_stall)
    else $error("input taken before text flushed");

  // the final byte of a text leaves the lookahead empty when it is loaded
  a_last_empty: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid && out_item.last_of_text) |-> !in_stall)
    else $error("last byte shown but lookahead not empty");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind utf8_text_pretoken_splitter_unit utps_checker u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_item  (out_item)
);

>>> tb/sv/utps_checker.sv
`timescale 1ns / 1ps
module utps_monitor import utps_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  output int        fail_count,
  output int        pending
);

  logic [7:0] held [0:LA_DEPTH-1];
  int         held_n;
  mode_t      open_mode;
  out_item_t  tagged_bytes [$];

  function automatic int byte_len(logic [7:0] b);
    if (b < 8'h80) return 1;
    if ((b & 8'hE0) == 8'hC0) return 2;
    if ((b & 8'hF0) == 8'hE0) return 3;
    if ((b & 8'hF8) == 8'hF0) return 4;
    return 1;
  endfunction

  function automatic logic [7:0] held_at(int i);
    if (i < held_n && i < LA_DEPTH) return held[i];
    return 8'h00;
  endfunction

  function automatic cp_t code_at(int i);
    logic [7:0] b, b1, b2, b3;
    b  = held_at(i);
    b1 = held_at(i + 1) & CONT_MSK;
    b2 = held_at(i + 2) & CONT_MSK;
    b3 = held_at(i + 3) & CONT_MSK;
    if (b < 8'h80) return cp_t'(b);
    if ((b & 8'hE0) == 8'hC0) return cp_t'({b[4:0], b1[5:0]});
    if ((b & 8'hF0) == 8'hE0) return cp_t'({b[3:0], b1[5:0], b2[5:0]});
    if ((b & 8'hF8) == 8'hF0) return cp_t'({b[2:0], b1[5:0], b2[5:0], b3[5:0]});
    return CP_BAD;
  endfunction

  function automatic logic rng(cp_t c, int lo, int hi);
    return int'(c) >= lo && int'(c) <= hi;
  endfunction

  function automatic logic letter_cp(cp_t c);
    return rng(c, 'h41, 'h5A) || rng(c, 'h61, 'h7A) ||
           (rng(c, 'hC0, 'hFF) && c != 'hD7 && c != 'hF7) ||
           rng(c, 'h100, 'h24F) || rng(c, 'h370, 'h4FF) || rng(c, 'h600, 'h6FF) ||
           rng(c, 'h900, 'h97F) || rng(c, 'h4E00, 'h9FFF) || rng(c, 'h3400, 'h4DBF) ||
           rng(c, 'hAC00, 'hD7AF) || rng(c, 'h3040, 'h30FF) || rng(c, 'hF900, 'hFAFF) ||
           rng(c, 'hFF21, 'hFF3A) || rng(c, 'hFF41, 'hFF5A) || rng(c, 'h0E01, 'h0E3A) ||
           rng(c, 'h05D0, 'h05EA) || rng(c, 'h1100, 'h11FF) || rng(c, 'h2E80, 'h2EFF) ||
           rng(c, 'h3000, 'h303F);
  endfunction

  function automatic logic mark_cp(cp_t c);
    return rng(c, 'h300, 'h36F) || rng(c, 'h591, 'h5BD) || rng(c, 'h610, 'h61A) ||
           rng(c, 'h64B, 'h65F) || rng(c, 'h900, 'h903) || rng(c, 'h93A, 'h94F) ||
           c == 'hE31 || rng(c, 'hE34, 'hE3A) || rng(c, 'hFE20, 'hFE2F) ||
           rng(c, 'h20D0, 'h20FF);
  endfunction

  function automatic logic digit_cp(cp_t c);
    return rng(c, 'h30, 'h39);
  endfunction

  function automatic logic space_cp(cp_t c);
    return c == 'h20 || rng(c, 'h09, 'h0D) || c == 'hA0 || c == 'h1680 ||
           rng(c, 'h2000, 'h200A) || c == 'h2028 || c == 'h2029 || c == 'h202F ||
           c == 'h205F || c == 'h3000;
  endfunction

  function automatic logic newline_cp(cp_t c);
    return c == 'h0A || c == 'h0D;
  endfunction

  function automatic logic punct_cp(cp_t c);
    return !space_cp(c) && !letter_cp(c) && !mark_cp(c) && !digit_cp(c);
  endfunction

  function automatic void release_front(int take, logic first, ref int made);
    out_item_t o;
    if (take > held_n) take = held_n;
    for (int j = 0; j < take; j++) begin
      o.out_byte = held[j];
      o.piece_start = first && j == 0;
      o.last_of_text = 1'b0;
      tagged_bytes.insert(tagged_bytes.size(), o);
      made++;
    end
    for (int j = 0; j < LA_DEPTH; j++)
      held[j] = (j + take < LA_DEPTH) ? held[j + take] : 8'h00;
    held_n -= take;
  endfunction

  function automatic void split_byte(in_item_t it);
    logic eot, cont, done, have1;
    int l0, l1, take, made;
    cp_t c0, c1;
    logic [7:0] x, y;
    mode_t m;
    eot = it.end_of_text;
    made = 0;
    if (held_n < LA_DEPTH) begin
      held[held_n] = it.text_byte;
      held_n++;
    end
    while (held_n > 0) begin
      l0 = byte_len(held[0]);
      if (l0 > held_n && !eot) break;
      c0 = code_at(0);
      if (open_mode != MODE_NONE) begin
        cont = 1'b0;
        case (open_mode)
          MODE_LETTERS: cont = letter_cp(c0) || mark_cp(c0);
          MODE_PUNCT: begin
            if (punct_cp(c0)) cont = 1'b1;
            else if (newline_cp(c0)) begin
              cont = 1'b1;
              open_mode = MODE_NL;
            end
          end
          MODE_WS: begin
            if (newline_cp(c0)) begin
              cont = 1'b1;
              open_mode = MODE_NL;
            end else if (space_cp(c0)) cont = 1'b1;
          end
          default: cont = newline_cp(c0);
        endcase
        if (cont) release_front(l0, 1'b0, made);
        else open_mode = MODE_NONE;
        continue;
      end
      take = l0;
      done = 1'b0;
      m = MODE_NONE;
      // apostrophe contractions; wait for the letters unless the text ends
      if (c0 == cp_t'(CH_APOS)) begin
        if (held_n < 2) begin
          if (!eot) break;
        end else begin
          x = held[1] | CASE_BIT;
          if (x inside {"s", "t", "m", "d"}) begin
            take = 2;
            done = 1'b1;
          end else if (x inside {"r", "v", "l"}) begin
            if (held_n < 3) begin
              if (!eot) break;
            end else begin
              y = held[2] | CASE_BIT;
              if (y == ((x == "l") ? 8'h6C : 8'h65)) begin
                take = 3;
                done = 1'b1;
              end
            end
          end
        end
      end
      if (!done) begin
        if (letter_cp(c0)) m = MODE_LETTERS;
        else if (digit_cp(c0)) m = MODE_NONE;
        else if (newline_cp(c0)) m = MODE_NL;
        else begin
          have1 = 1'b0;
          c1 = '0;
          if (l0 < held_n) begin
            l1 = byte_len(held[l0]);
            if (l0 + l1 > held_n && !eot) break;
            c1 = code_at(l0);
            have1 = 1'b1;
          end else if (!eot) break;
          if (have1 && (letter_cp(c1) || mark_cp(c1))) m = MODE_LETTERS;
          else if (c0 == cp_t'(CH_SPACE) && have1 && punct_cp(c1)) m = MODE_PUNCT;
          else if (punct_cp(c0)) m = MODE_PUNCT;
          else if (space_cp(c0)) m = MODE_WS;
          else m = MODE_NONE;
        end
      end
      release_front(take, 1'b1, made);
      open_mode = m;
    end
    if (eot) begin
      if (made > 0) tagged_bytes[tagged_bytes.size() - 1].last_of_text = 1'b1;
      held_n = 0;
      open_mode = MODE_NONE;
    end
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      held_n = 0;
      open_mode = MODE_NONE;
      fail_count = 0;
      tagged_bytes.delete();
      for (int j = 0; j < LA_DEPTH; j++) held[j] = 8'h00;
    end else begin
      if (out_valid && !out_stall) begin
        if (tagged_bytes.size() == 0) begin
          $error("unexpected item byte=%h", out_item.out_byte);
          fail_count++;
        end else begin
          want = tagged_bytes.pop_front();
          if (want.out_byte !== out_item.out_byte) begin
            $error("out_byte expected %h actual %h", want.out_byte, out_item.out_byte);
            fail_count++;
          end
          if (want.piece_start !== out_item.piece_start) begin
            $error("piece_start expected %b actual %b", want.piece_start,
                   out_item.piece_start);
            fail_count++;
          end
          if (want.last_of_text !== out_item.last_of_text) begin
            $error("last_of_text expected %b actual %b", want.last_of_text,
                   out_item.last_of_text);
            fail_count++;
          end
        end
      end
      if (in_valid && !in_stall) split_byte(in_item);
    end
    pending = tagged_bytes.size();
  end

endmodule

>>> tb/sv/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
  import utps_pkg::*;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_item = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_item;
  int        fail_count;
  int        pending;
  int        cycles = 0;
  logic      hold_off = 1'b0;

  always #5 clk = ~clk;

  utf8_text_pretoken_splitter_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item)
  );

  utps_monitor chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_item(in_item), .out_valid(out_valid), .out_stall(out_stall),
    .out_item(out_item), .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // receiver: random stalls outside a periodic stall-free window, plus one long hold-off on request
  always @(posedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else if (hold_off) out_stall <= 1'b1;
    else if (cycles % 600 < 150) out_stall <= 1'b0;
    else out_stall <= (gap_len() > 0);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("utf8_text_pretoken_splitter_unit verification failed");
      $finish;
    end
  end

  task automatic send(logic [7:0] b, logic eot, logic gaps);
    int g;
    g = gaps ? gap_len() : 0;
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item <= '{text_byte: b, end_of_text: eot};
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic send_text(logic [7:0] t [$], logic gaps);
    foreach (t[i]) send(t[i], i == t.size() - 1, gaps);
  endtask

  function automatic void put_byte(ref logic [7:0] t [$], input logic [7:0] b);
    t.insert(t.size(), b);
  endfunction

  function automatic void add_char(ref logic [7:0] t [$]);
    int k;
    logic [7:0] s [$];
    k = $urandom_range(0, 19);
    case (k)
      0, 1, 2: put_byte(t, 8'(8'h61 + $urandom_range(0, 25)));
      3: put_byte(t, 8'(8'h41 + $urandom_range(0, 25)));
      4: put_byte(t, 8'(8'h30 + $urandom_range(0, 9)));
      5, 6: put_byte(t, CH_SPACE);
      7: put_byte(t, $urandom_range(0, 1) ? 8'h0A : 8'h0D);
      8: put_byte(t, 8'(8'h21 + $urandom_range(0, 14)));
      9: begin
        s = '{CH_APOS, "s", "r", "e", "l", "l", "V", "E", "t", "x", "D", "m"};
        put_byte(t, CH_APOS);
        put_byte(t, s[$urandom_range(1, 11)]);
        if ($urandom_range(0, 1)) put_byte(t, s[$urandom_range(1, 11)]);
      end
      10: begin
        put_byte(t, 8'(8'hC0 | $urandom_range(0, 31)));
        put_byte(t, 8'(8'h80 | $urandom_range(0, 63)));
      end
      11: begin // combining mark
        put_byte(t, 8'(8'hCC | $urandom_range(0, 1)));
        put_byte(t, 8'(8'h80 | $urandom_range(0, 63)));
      end
      12: begin // CJK / Hangul / ideographic space
        put_byte(t, 8'(8'hE0 | $urandom_range(0, 15)));
        put_byte(t, 8'(8'h80 | $urandom_range(0, 63)));
        put_byte(t, 8'(8'h80 | $urandom_range(0, 63)));
      end
      13: begin
        put_byte(t, 8'(8'hF0 | $urandom_range(0, 7)));
        repeat (3) put_byte(t, 8'(8'h80 | $urandom_range(0, 63)));
      end
      14: put_byte(t, 8'(8'h80 | $urandom_range(0, 63)));
      15: put_byte(t, 8'(8'hF8 | $urandom_range(0, 7)));
      16: put_byte(t, 8'($urandom_range(0, 255)));
      17: put_byte(t, 8'h09);
      default: put_byte(t, 8'(8'h61 + $urandom_range(0, 25)));
    endcase
  endfunction

  initial begin
    logic [7:0] t [$];
    int sent;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: contractions, letters, digits, punct runs, spaces, newlines
    t = '{"I", CH_APOS, "L", "L", CH_SPACE, "g", "o", CH_APOS, "s", CH_SPACE,
          "4", "2", CH_SPACE, "!", "?", 8'h0A, 8'h0D, 8'h09, CH_SPACE, 8'h0A, "x"};
    send_text(t, 1'b0);
    // stray and extreme bytes, mark after letter, 4-byte char
    t = '{8'h00, 8'hFF, 8'h80, "e", 8'hCC, 8'h81, 8'hF0, 8'h9F, 8'h98, 8'h80};
    send_text(t, 1'b1);
    // truncated sequence and dangling apostrophe at end of text
    t = '{"a", 8'hE4, 8'hB8};
    send_text(t, 1'b0);
    t = '{CH_APOS, "r"};
    send_text(t, 1'b0);
    t = '{CH_APOS};
    send_text(t, 1'b0);
    t = '{8'h7F};
    send_text(t, 1'b0);

    // sender pauses until every expected item is out
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    // receiver holds off long while the sender keeps going
    hold_off <= 1'b1;
    fork
      begin
        repeat (60) @(posedge clk);
        hold_off <= 1'b0;
      end
    join_none
    t = {};
    repeat (30) add_char(t);
    send_text(t, 1'b0);

    sent = 0;
    while (sent < 85) begin
      t = {};
      repeat ($urandom_range(1, 12)) add_char(t);
      send_text(t, 1'b1);
      sent += t.size();
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (fail_count == 0 && pending == 0)
      $display("utf8_text_pretoken_splitter_unit verification clean");
    else
      $display("utf8_text_pretoken_splitter_unit verification failed");
    $finish;
  end

endmodule
